>>> rtl/nbfe_pkg.sv
package nbfe_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_REPLY   = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // Verdict codes
   localparam logic [1:0] VERD_OK         = 2'd0;
   localparam logic [1:0] VERD_BAD_SUM    = 2'd1;
   localparam logic [1:0] VERD_STATUS     = 2'd2;
   localparam logic [1:0] VERD_UNEXPECTED = 2'd3;

   // Frame constants and limits
   localparam logic [7:0] HDR_FLAG    = 8'h80;
   localparam logic [7:0] MASK_RESET  = 8'h0c;
   localparam logic [6:0] MAX_PAYLOAD = 7'd76;
   localparam logic [5:0] MAX_REPLY   = 6'd62;

   // Most results one transaction can cause
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] node;
      logic [6:0] payload_len;
      logic [5:0] reply_size;
      logic [7:0] data_byte;
   } nbfe_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [1:0] verdict;
      logic       last;
   } nbfe_result_type;

   typedef struct packed {
      logic [2:0]                        count;
      nbfe_result_type [MAX_RESULTS-1:0] res;
   } nbfe_batch_type;

endpackage

>>> rtl/nbfe_req_if.sv
interface nbfe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [6:0] node;
   logic [6:0] payload_len;
   logic [5:0] reply_size;
   logic [7:0] data_byte;

   modport source (output valid, command, node, payload_len, reply_size, data_byte,
                   input ready);
   modport sink   (input valid, command, node, payload_len, reply_size, data_byte,
                   output ready);
endinterface

>>> rtl/nbfe_rsp_if.sv
interface nbfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [1:0] verdict;
   logic       last;

   modport source (output valid, kind, out_byte, verdict, last, input ready);
   modport sink   (input valid, kind, out_byte, verdict, last, output ready);
endinterface

>>> rtl/nbfe_framer.sv
module nbfe_framer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    csr_wr_en,
   input  logic [7:0]              csr_wr_data,
   input  nbfe_pkg::nbfe_item_type item,
   output nbfe_pkg::nbfe_batch_type batch
);
   import nbfe_pkg::*;

   logic [7:0] mask_ff;
   logic [7:0] tx_sum_ff, tx_sum_in;
   logic [6:0] tx_left_ff, tx_left_in;
   logic       tx_open_ff, tx_open_in;
   logic [5:0] rx_expected_ff, rx_expected_in;
   logic [5:0] rx_count_ff, rx_count_in;
   logic [7:0] rx_sum_ff, rx_sum_in;
   logic       rx_open_ff, rx_open_in;

   logic [7:0] hdr_byte;
   logic [7:0] len_byte;
   logic [7:0] start_sum;
   logic [7:0] pay_sum;
   logic [6:0] pay_left;
   logic [7:0] rx_sum_next;
   logic [7:0] rl_start;
   logic [7:0] rl_open;

   function automatic nbfe_result_type mk_res(input logic [1:0] kind,
                                              input logic [7:0] b,
                                              input logic [1:0] verd,
                                              input logic       last);
      nbfe_result_type r;
      r.kind     = kind;
      r.out_byte = b;
      r.verdict  = verd;
      r.last     = last;
      return r;
   endfunction

   // Byte arithmetic shared by the command arms
   always_comb begin
      hdr_byte    = HDR_FLAG | {1'b0, item.node};
      len_byte    = {1'b0, item.payload_len} + 8'd1;
      start_sum   = hdr_byte + len_byte;
      pay_sum     = tx_sum_ff + item.data_byte;
      pay_left    = tx_left_ff - 7'd1;
      rx_sum_next = rx_sum_ff + item.data_byte;
      rl_start    = (item.reply_size != 6'd0) ? ({2'b00, item.reply_size} + 8'd2) : 8'd0;
      rl_open     = (rx_expected_ff != 6'd0) ? ({2'b00, rx_expected_ff} + 8'd2) : 8'd0;
   end

   // Results and next state for one transaction
   always_comb begin
      tx_sum_in      = tx_sum_ff;
      tx_left_in     = tx_left_ff;
      tx_open_in     = tx_open_ff;
      rx_expected_in = rx_expected_ff;
      rx_count_in    = rx_count_ff;
      rx_sum_in      = rx_sum_ff;
      rx_open_in     = rx_open_ff;
      batch          = '0;

      case (item.command)
         CMD_START: begin
            tx_open_in     = 1'b0;
            tx_left_in     = 7'd0;
            tx_sum_in      = 8'd0;
            rx_open_in     = 1'b0;
            rx_count_in    = 6'd0;
            rx_sum_in      = 8'd0;
            rx_expected_in = 6'd0;
            if (item.payload_len > MAX_PAYLOAD || item.reply_size > MAX_REPLY) begin
               batch.count  = 3'd1;
               batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_UNEXPECTED, 1'b1);
            end else begin
               rx_expected_in = item.reply_size;
               batch.res[0]   = mk_res(KIND_TX, hdr_byte, VERD_OK, 1'b0);
               if (item.payload_len == 7'd0) begin
                  // empty payload closes the frame at once
                  batch.count  = 3'd4;
                  batch.res[1] = mk_res(KIND_TX, len_byte, VERD_OK, 1'b0);
                  batch.res[2] = mk_res(KIND_TX, 8'd0 - start_sum, VERD_OK, 1'b0);
                  batch.res[3] = mk_res(KIND_TX, rl_start, VERD_OK, 1'b1);
                  rx_open_in   = (item.reply_size != 6'd0);
               end else begin
                  batch.count  = 3'd2;
                  batch.res[1] = mk_res(KIND_TX, len_byte, VERD_OK, 1'b1);
                  tx_open_in   = 1'b1;
                  tx_left_in   = item.payload_len;
                  tx_sum_in    = start_sum;
               end
            end
         end
         CMD_PAYLOAD: begin
            if (!tx_open_ff || tx_left_ff == 7'd0) begin
               batch.count  = 3'd1;
               batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_UNEXPECTED, 1'b1);
            end else if (pay_left == 7'd0) begin
               // last counted byte: checksum and reply length follow
               batch.count  = 3'd3;
               batch.res[0] = mk_res(KIND_TX, item.data_byte, VERD_OK, 1'b0);
               batch.res[1] = mk_res(KIND_TX, 8'd0 - pay_sum, VERD_OK, 1'b0);
               batch.res[2] = mk_res(KIND_TX, rl_open, VERD_OK, 1'b1);
               tx_open_in   = 1'b0;
               tx_left_in   = 7'd0;
               tx_sum_in    = 8'd0;
               rx_count_in  = 6'd0;
               rx_sum_in    = 8'd0;
               rx_open_in   = (rx_expected_ff != 6'd0);
            end else begin
               batch.count  = 3'd1;
               batch.res[0] = mk_res(KIND_TX, item.data_byte, VERD_OK, 1'b1);
               tx_sum_in    = pay_sum;
               tx_left_in   = pay_left;
            end
         end
         CMD_REPLY: begin
            if (!rx_open_ff) begin
               batch.count  = 3'd1;
               batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_UNEXPECTED, 1'b1);
            end else if (rx_count_ff < rx_expected_ff) begin
               batch.count  = 3'd1;
               batch.res[0] = mk_res(KIND_DATA, item.data_byte, VERD_OK, 1'b1);
               rx_sum_in    = rx_sum_next;
               rx_count_in  = rx_count_ff + 6'd1;
            end else if (rx_count_ff == rx_expected_ff) begin
               // checksum byte: summed, no result
               rx_sum_in   = rx_sum_next;
               rx_count_in = rx_count_ff + 6'd1;
            end else begin
               // status byte closes the reply
               batch.count = 3'd1;
               if (rx_sum_ff != 8'd0) begin
                  batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_BAD_SUM, 1'b1);
               end else if ((item.data_byte & mask_ff) != 8'd0) begin
                  batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_STATUS, 1'b1);
               end else begin
                  batch.res[0] = mk_res(KIND_VERDICT, 8'd0, VERD_OK, 1'b1);
               end
               rx_open_in     = 1'b0;
               rx_count_in    = 6'd0;
               rx_sum_in      = 8'd0;
               rx_expected_in = 6'd0;
            end
         end
         default: begin
            batch.count = 3'd0;
         end
      endcase
   end

   // Frame state, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= MASK_RESET;
         tx_sum_ff      <= 8'd0;
         tx_left_ff     <= 7'd0;
         tx_open_ff     <= 1'b0;
         rx_expected_ff <= 6'd0;
         rx_count_ff    <= 6'd0;
         rx_sum_ff      <= 8'd0;
         rx_open_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (step_en) begin
            tx_sum_ff      <= tx_sum_in;
            tx_left_ff     <= tx_left_in;
            tx_open_ff     <= tx_open_in;
            rx_expected_ff <= rx_expected_in;
            rx_count_ff    <= rx_count_in;
            rx_sum_ff      <= rx_sum_in;
            rx_open_ff     <= rx_open_in;
         end
      end
   end

endmodule

>>> rtl/node_bus_frame_engine.sv
// Bus-master framer for an addressed node bus. Each request transaction is
// worked combinationally against the frame state and its results (up to
// four: header, length, checksum and reply-length bytes for a start with no
// payload) are loaded into a four-entry result register, which hands out one
// result per cycle on the response channel while rsp_chan.ready is high.
// A request causes 1, 2 or 4 results for a start, 1 or 3 for a payload
// byte and 0 or 1 for a reply byte. The next request is taken in the same
// cycle as the last buffered result, or whenever the buffer is empty.
// status_error_mask (reset 0x0c) selects the status bits that count as a
// node error; write it only while no transaction is in flight.
module node_bus_frame_engine (
   input  logic             clock,
   input  logic             reset,
   nbfe_req_if.sink         req_chan,
   nbfe_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import nbfe_pkg::*;

   nbfe_item_type   item;
   nbfe_batch_type  batch;
   nbfe_result_type res_ff [MAX_RESULTS];
   nbfe_result_type head_res;
   logic [1:0]      head_ff;
   logic [2:0]      cnt_ff;
   logic            accept;
   logic            take;

   assign item.command     = req_chan.command;
   assign item.node        = req_chan.node;
   assign item.payload_len = req_chan.payload_len;
   assign item.reply_size  = req_chan.reply_size;
   assign item.data_byte   = req_chan.data_byte;

   nbfe_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .batch       (batch)
   );

   // Handshakes: accept while the buffer is empty or empties in this cycle
   assign take           = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // Response drive from the head entry
   assign head_res          = res_ff[head_ff];
   assign rsp_chan.valid    = (cnt_ff != 3'd0);
   assign rsp_chan.kind     = head_res.kind;
   assign rsp_chan.out_byte = head_res.out_byte;
   assign rsp_chan.verdict  = head_res.verdict;
   assign rsp_chan.last     = head_res.last;

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_ff[i] <= batch.res[i];
         end
      end
   end

   // Result count and head pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 2'd0;
         cnt_ff  <= 3'd0;
      end else if (accept) begin
         head_ff <= 2'd0;
         cnt_ff  <= batch.count;
      end else if (take) begin
         head_ff <= head_ff + 2'd1;
         cnt_ff  <= cnt_ff - 3'd1;
      end
   end

endmodule
